/* src/dsfm_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the direct-sound FIFO mixer.
package dsfm_pkg;

	localparam int SAMPLE_W = 16;
	localparam int BYTE_W   = 8;
	localparam int CNT_W    = 8;
	localparam int BIAS_W   = 10;
	localparam int AMP_W    = 4;
	localparam int ROUTE_W  = 4;
	localparam int OP_W     = 3;
	localparam int PADDR_W  = 5;
	localparam int PDATA_W  = 32;
	localparam int REG_IDX_W = 3;

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [BYTE_W-1:0]   byte_t;
	typedef logic [OP_W-1:0]     op_code_t;
	typedef logic [REG_IDX_W-1:0] reg_idx_t;

	localparam op_code_t OP_WRITE_A    = 3'd0;
	localparam op_code_t OP_WRITE_B    = 3'd1;
	localparam op_code_t OP_TIMER      = 3'd2;
	localparam op_code_t OP_TICK       = 3'd3;
	localparam op_code_t OP_FIFO_RESET = 3'd4;

	localparam reg_idx_t REG_MASTER_ENABLE = 3'd0;
	localparam reg_idx_t REG_FIFO_A_TIMER  = 3'd1;
	localparam reg_idx_t REG_FIFO_B_TIMER  = 3'd2;
	localparam reg_idx_t REG_FIFO_A_FULL   = 3'd3;
	localparam reg_idx_t REG_FIFO_B_FULL   = 3'd4;
	localparam reg_idx_t REG_ROUTING       = 3'd5;
	localparam reg_idx_t REG_BIAS_LEVEL    = 3'd6;
	localparam reg_idx_t REG_AMPLIFICATION = 3'd7;

	localparam logic [BIAS_W-1:0] CLAMP_MAX  = 10'h3FF;
	localparam logic [BIAS_W-1:0] BIAS_RESET = 10'd256;
	localparam logic [AMP_W-1:0]  AMP_RESET  = 4'd1;
	localparam logic [CNT_W-1:0]  CNT_MAX    = 8'hFF;

endpackage

/* src/dsfm_cmd_if.sv */
`timescale 1ns / 1ps
// Command channel: FIFO writes, timer overflows, output ticks, FIFO resets.
interface dsfm_cmd_if;
	logic               valid;
	logic               ready;
	dsfm_pkg::op_code_t op;
	dsfm_pkg::byte_t    byte_data;
	logic               timer_id;
	logic               fifo_select;

	modport source (output valid, op, byte_data, timer_id, fifo_select, input ready);
	modport sink (input valid, op, byte_data, timer_id, fifo_select, output ready);
endinterface

/* src/dsfm_res_if.sv */
`timescale 1ns / 1ps
// Result channel: mixed samples and DMA requests.
interface dsfm_res_if;
	logic              valid;
	logic              ready;
	logic              sample_valid;
	dsfm_pkg::sample_t left_out;
	dsfm_pkg::sample_t right_out;
	logic              dma_request_a;
	logic              dma_request_b;

	modport source (output valid, sample_valid, left_out, right_out, dma_request_a,
		dma_request_b, input ready);
	modport sink (input valid, sample_valid, left_out, right_out, dma_request_a,
		dma_request_b, output ready);
endinterface

/* src/dsfm_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module dsfm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* src/direct_sound_fifo_mixer.sv */
`timescale 1ns / 1ps
// Direct-sound FIFO mixer top level: two sample FIFOs in RAM, averaging and mixing.
// A FIFO write or FIFO reset is handled in the idle state and gives no word. A timer
// overflow goes through the pop state, which uses the registered read of the FIFO RAMs,
// and gives one word with the DMA requests. For an output tick, both channel averages
// run through a 16-step restoring divider (one quotient bit per cycle, the two channels
// side by side), then the mix state does routing, bias and clamp and the final state
// bias removal and gain. One item is in work at a time; the finished word sits in an
// output register, so a new item is taken while the word waits, and a word-producing
// item holds only if that register is still full when it completes. No clearing pass
// follows reset: FIFO entries are read only after they were written.
module direct_sound_fifo_mixer #(
	parameter int FIFO_DEPTH    = 32,
	parameter int DMA_THRESHOLD = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	dsfm_cmd_if.sink                      cmd,
	dsfm_res_if.source                    result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [dsfm_pkg::PADDR_W-1:0]  paddr,
	input  logic [dsfm_pkg::PDATA_W-1:0]  pwdata,
	output logic [dsfm_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);

	localparam int AW = $clog2(FIFO_DEPTH);
	localparam int LW = $clog2(FIFO_DEPTH + 1);
	localparam int DIV_STEPS = dsfm_pkg::SAMPLE_W;
	localparam int DCW = $clog2(DIV_STEPS);

	typedef enum logic [2:0] {ST_IDLE, ST_POP, ST_DIV, ST_MIX, ST_FIN} state_t;

	state_t state_q;

	// configuration
	logic                          master_en_q;
	logic [1:0]                    tmr_q;
	logic [1:0]                    full_q;
	logic [dsfm_pkg::ROUTE_W-1:0]  routing_q;
	logic [dsfm_pkg::BIAS_W-1:0]   bias_q;
	logic [dsfm_pkg::AMP_W-1:0]    amp_q;

	// per-channel state
	logic [LW-1:0]                 lvl_q [2];
	logic [AW-1:0]                 rd_q [2];
	dsfm_pkg::sample_t             sum_q [2];
	logic [dsfm_pkg::CNT_W-1:0]    cnt_q [2];
	logic [1:0]                    pop_q;

	// divider
	logic [DCW-1:0]                div_cnt_q;
	logic [1:0]                    neg_q;
	dsfm_pkg::sample_t             mag_q [2];
	logic [dsfm_pkg::CNT_W-1:0]    den_q [2];
	logic [dsfm_pkg::CNT_W-1:0]    rem_q [2];
	logic [dsfm_pkg::BIAS_W-1:0]   clamp_q [2];

	// result register
	logic                          res_valid_q;
	logic                          res_sample_q;
	dsfm_pkg::sample_t             res_left_q;
	dsfm_pkg::sample_t             res_right_q;
	logic                          res_dma_a_q;
	logic                          res_dma_b_q;

	// RAM ports
	logic                          ram_we [2];
	logic [AW-1:0]                 ram_waddr [2];
	dsfm_pkg::byte_t               ram_rdata [2];

	// combinational
	logic                          acc;
	logic                          cfg_wr;
	dsfm_pkg::reg_idx_t            cfg_idx;
	logic                          out_free;
	logic [AW:0]                   wsum [2];
	logic                          can_push [2];
	dsfm_pkg::byte_t               pop_byte [2];
	dsfm_pkg::sample_t             pop_ext [2];
	dsfm_pkg::sample_t             pop_val [2];
	dsfm_pkg::sample_t             sum_nx [2];
	logic [dsfm_pkg::CNT_W-1:0]    cnt_nx [2];
	logic [LW-1:0]                 lvl_nx [2];
	logic [AW-1:0]                 rd_nx [2];
	logic [1:0]                    dma_nx;
	logic [dsfm_pkg::CNT_W:0]      trial [2];
	logic [1:0]                    qbit;
	dsfm_pkg::sample_t             avg [2];
	dsfm_pkg::sample_t             mix [2];
	dsfm_pkg::sample_t             biased [2];
	logic [dsfm_pkg::BIAS_W-1:0]   clamp_nx [2];
	logic [dsfm_pkg::BIAS_W:0]     diff [2];
	dsfm_pkg::sample_t             scaled [2];

	assign acc      = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == ST_IDLE);
	assign out_free = !res_valid_q || result.ready;
	assign cfg_wr   = psel && penable && pwrite;
	assign cfg_idx  = paddr[dsfm_pkg::PADDR_W-1:2];
	assign pready   = 1'b1;

	assign result.valid         = res_valid_q;
	assign result.sample_valid  = res_sample_q;
	assign result.left_out      = res_left_q;
	assign result.right_out     = res_right_q;
	assign result.dma_request_a = res_dma_a_q;
	assign result.dma_request_b = res_dma_b_q;

	always_comb begin
		prdata = '0;
		unique case (cfg_idx)
			dsfm_pkg::REG_MASTER_ENABLE: prdata[0] = master_en_q;
			dsfm_pkg::REG_FIFO_A_TIMER:  prdata[0] = tmr_q[0];
			dsfm_pkg::REG_FIFO_B_TIMER:  prdata[0] = tmr_q[1];
			dsfm_pkg::REG_FIFO_A_FULL:   prdata[0] = full_q[0];
			dsfm_pkg::REG_FIFO_B_FULL:   prdata[0] = full_q[1];
			dsfm_pkg::REG_ROUTING:       prdata[dsfm_pkg::ROUTE_W-1:0] = routing_q;
			dsfm_pkg::REG_BIAS_LEVEL:    prdata[dsfm_pkg::BIAS_W-1:0] = bias_q;
			dsfm_pkg::REG_AMPLIFICATION: prdata[dsfm_pkg::AMP_W-1:0] = amp_q;
		endcase
	end

	always_comb begin
		for (int c = 0; c < 2; c++) begin
			// push address: head plus level, wrapped
			wsum[c] = {1'b0, rd_q[c]} + (AW+1)'(lvl_q[c]);
			ram_waddr[c] = (wsum[c] >= (AW+1)'(FIFO_DEPTH)) ?
				AW'(wsum[c] - (AW+1)'(FIFO_DEPTH)) : AW'(wsum[c]);
			can_push[c] = lvl_q[c] < LW'(FIFO_DEPTH);

			// pop
			pop_byte[c] = (lvl_q[c] != '0) ? ram_rdata[c] : '0;
			pop_ext[c]  = {{(dsfm_pkg::SAMPLE_W-dsfm_pkg::BYTE_W){pop_byte[c][7]}}, pop_byte[c]};
			pop_val[c]  = full_q[c] ? pop_ext[c] :
				{{2{pop_ext[c][15]}}, pop_ext[c][15:2]};
			sum_nx[c] = (cnt_q[c] == '0) ? pop_val[c] : sum_q[c] + pop_val[c];
			cnt_nx[c] = (cnt_q[c] == dsfm_pkg::CNT_MAX) ? cnt_q[c] : cnt_q[c] + 1'b1;
			lvl_nx[c] = (lvl_q[c] == '0) ? lvl_q[c] : lvl_q[c] - 1'b1;
			rd_nx[c]  = (lvl_q[c] == '0) ? rd_q[c] :
				(rd_q[c] == AW'(FIFO_DEPTH - 1)) ? '0 : rd_q[c] + 1'b1;
			dma_nx[c] = pop_q[c] && (32'(lvl_nx[c]) <= DMA_THRESHOLD);

			// restoring divide step
			trial[c] = {rem_q[c], mag_q[c][15]};
			qbit[c]  = trial[c] >= {1'b0, den_q[c]};

			// sign restore, routing, bias, clamp, bias removal, gain
			avg[c] = neg_q[c] ? (~mag_q[c] + 16'd1) : mag_q[c];
		end
		mix[0] = (routing_q[0] ? avg[0] : '0) + (routing_q[2] ? avg[1] : '0);
		mix[1] = (routing_q[1] ? avg[0] : '0) + (routing_q[3] ? avg[1] : '0);
		for (int c = 0; c < 2; c++) begin
			biased[c] = mix[c] + {{(dsfm_pkg::SAMPLE_W-dsfm_pkg::BIAS_W){1'b0}}, bias_q};
			if (biased[c][15]) begin
				clamp_nx[c] = '0;
			end else if (biased[c][14:10] != '0) begin
				clamp_nx[c] = dsfm_pkg::CLAMP_MAX;
			end else begin
				clamp_nx[c] = biased[c][9:0];
			end
			diff[c]   = {1'b0, clamp_q[c]} - {1'b0, bias_q};
			scaled[c] = {{(dsfm_pkg::SAMPLE_W-dsfm_pkg::BIAS_W-1){diff[c][10]}}, diff[c]} *
				{{(dsfm_pkg::SAMPLE_W-dsfm_pkg::AMP_W){1'b0}}, amp_q};
		end
		ram_we[0] = acc && (cmd.op == dsfm_pkg::OP_WRITE_A) && can_push[0];
		ram_we[1] = acc && (cmd.op == dsfm_pkg::OP_WRITE_B) && can_push[1];
	end

	dsfm_ram #(.WIDTH(dsfm_pkg::BYTE_W), .DEPTH(FIFO_DEPTH)) u_ram_a (
		.clk   (clk),
		.we    (ram_we[0]),
		.waddr (ram_waddr[0]),
		.wdata (cmd.byte_data),
		.raddr (rd_q[0]),
		.rdata (ram_rdata[0])
	);

	dsfm_ram #(.WIDTH(dsfm_pkg::BYTE_W), .DEPTH(FIFO_DEPTH)) u_ram_b (
		.clk   (clk),
		.we    (ram_we[1]),
		.waddr (ram_waddr[1]),
		.wdata (cmd.byte_data),
		.raddr (rd_q[1]),
		.rdata (ram_rdata[1])
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			master_en_q  <= 1'b0;
			tmr_q        <= '0;
			full_q       <= '0;
			routing_q    <= '0;
			bias_q       <= dsfm_pkg::BIAS_RESET;
			amp_q        <= dsfm_pkg::AMP_RESET;
			for (int c = 0; c < 2; c++) begin
				lvl_q[c] <= '0;
				rd_q[c]  <= '0;
				sum_q[c] <= '0;
				cnt_q[c] <= '0;
			end
			pop_q        <= '0;
			div_cnt_q    <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			if (result.ready) begin
				res_valid_q <= 1'b0;
			end

			if (cfg_wr) begin
				unique case (cfg_idx)
					dsfm_pkg::REG_MASTER_ENABLE: begin
						master_en_q <= pwdata[0];
						if (!pwdata[0]) begin
							for (int c = 0; c < 2; c++) begin
								sum_q[c] <= '0;
								cnt_q[c] <= '0;
							end
						end
					end
					dsfm_pkg::REG_FIFO_A_TIMER:  tmr_q[0]  <= pwdata[0];
					dsfm_pkg::REG_FIFO_B_TIMER:  tmr_q[1]  <= pwdata[0];
					dsfm_pkg::REG_FIFO_A_FULL:   full_q[0] <= pwdata[0];
					dsfm_pkg::REG_FIFO_B_FULL:   full_q[1] <= pwdata[0];
					dsfm_pkg::REG_ROUTING:       routing_q <= pwdata[dsfm_pkg::ROUTE_W-1:0];
					dsfm_pkg::REG_BIAS_LEVEL:    bias_q    <= pwdata[dsfm_pkg::BIAS_W-1:0];
					dsfm_pkg::REG_AMPLIFICATION: amp_q     <= pwdata[dsfm_pkg::AMP_W-1:0];
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						priority case (cmd.op)
							dsfm_pkg::OP_WRITE_A: begin
								if (can_push[0]) begin
									lvl_q[0] <= lvl_q[0] + 1'b1;
								end
							end
							dsfm_pkg::OP_WRITE_B: begin
								if (can_push[1]) begin
									lvl_q[1] <= lvl_q[1] + 1'b1;
								end
							end
							dsfm_pkg::OP_TIMER: begin
								for (int c = 0; c < 2; c++) begin
									pop_q[c] <= master_en_q && (tmr_q[c] == cmd.timer_id);
								end
								state_q <= ST_POP;
							end
							dsfm_pkg::OP_TICK: begin
								for (int c = 0; c < 2; c++) begin
									neg_q[c] <= sum_q[c][15];
									mag_q[c] <= sum_q[c][15] ? (~sum_q[c] + 16'd1) : sum_q[c];
									den_q[c] <= (cnt_q[c] == '0) ? 8'd1 : cnt_q[c];
									rem_q[c] <= '0;
									cnt_q[c] <= '0;
								end
								div_cnt_q <= DCW'(DIV_STEPS - 1);
								state_q   <= ST_DIV;
							end
							dsfm_pkg::OP_FIFO_RESET: begin
								if (cmd.fifo_select) begin
									lvl_q[1] <= '0;
								end else begin
									lvl_q[0] <= '0;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_POP: begin
					if (out_free) begin
						for (int c = 0; c < 2; c++) begin
							if (pop_q[c]) begin
								sum_q[c] <= sum_nx[c];
								cnt_q[c] <= cnt_nx[c];
								lvl_q[c] <= lvl_nx[c];
								rd_q[c]  <= rd_nx[c];
							end
						end
						res_valid_q  <= 1'b1;
						res_sample_q <= 1'b0;
						res_left_q   <= '0;
						res_right_q  <= '0;
						res_dma_a_q  <= dma_nx[0];
						res_dma_b_q  <= dma_nx[1];
						state_q      <= ST_IDLE;
					end
				end
				ST_DIV: begin
					for (int c = 0; c < 2; c++) begin
						rem_q[c] <= qbit[c] ? dsfm_pkg::CNT_W'(trial[c] - {1'b0, den_q[c]}) :
							dsfm_pkg::CNT_W'(trial[c]);
						mag_q[c] <= {mag_q[c][14:0], qbit[c]};
					end
					div_cnt_q <= div_cnt_q - 1'b1;
					if (div_cnt_q == '0) begin
						state_q <= ST_MIX;
					end
				end
				ST_MIX: begin
					for (int c = 0; c < 2; c++) begin
						clamp_q[c] <= clamp_nx[c];
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						res_valid_q  <= 1'b1;
						res_sample_q <= 1'b1;
						res_left_q   <= scaled[0];
						res_right_q  <= scaled[1];
						res_dma_a_q  <= 1'b0;
						res_dma_b_q  <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		lvl_q[0] <= LW'(FIFO_DEPTH) && lvl_q[1] <= LW'(FIFO_DEPTH))
		else $error("FIFO level above depth");

	a_tick_no_dma: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.sample_valid |-> !result.dma_request_a && !result.dma_request_b)
		else $error("DMA request on a mixed sample word");

	a_tick_clears_count: assert property (@(posedge clk) disable iff (!arst_n)
		acc && cmd.op == dsfm_pkg::OP_TICK |=> cnt_q[0] == '0 && cnt_q[1] == '0)
		else $error("counts not cleared by output tick");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		acc && cmd.op == dsfm_pkg::OP_WRITE_A && lvl_q[0] == LW'(FIFO_DEPTH)
		|=> lvl_q[0] == LW'(FIFO_DEPTH))
		else $error("write to full FIFO A changed its level");

endmodule
